[src/assert_macros.svh]
// Assertion macros, empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[src/sapc_pkg.sv]
package sapc_pkg;
	localparam int CW = 32;
	localparam int FB = 24;
	localparam int QW = FB + 1;
	localparam int DW = CW + 1;
	localparam int PW = DW + QW;
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;
	localparam logic [1:0] AX_NONE = 2'd3;
	localparam logic [15:0] MIN_SPAN_RST = 16'd2;
	localparam int DIV_ST = QW;
	localparam int NST = DIV_ST + 6;
	localparam int SW = $clog2(NST + 2) + 1;

	typedef struct packed {
		logic ok;
		logic [2:0][CW-1:0] s;
		logic [2:0][DW-1:0] d;
		logic [DW-1:0] den;
		logic [DW:0] rem;
		logic [QW-1:0] q;
	} div_t;
endpackage

[src/segment_axis_plane_clip.sv]
// Segment against axis-aligned plane clip. One transaction per cycle sustained
// while the output queue has a free entry. The path from input to output runs
// through two setup stages, one restoring divider stage per quotient bit, 25 in
// all, a 33x25 split multiply over three stages, a final add, then a two-entry
// output queue. When tready drops the whole pipeline stalls once the queue
// holds two results, so nothing is lost.
`include "assert_macros.svh"
module segment_axis_plane_clip (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [223:0] s_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z, plane_coord
	input  logic [1:0]   s_tuser,  // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,  // point_x, point_y, point_z, 8 zero bits
	output logic         m_tuser   // hit
);
	localparam int CW = sapc_pkg::CW;
	localparam int DW = sapc_pkg::DW;
	localparam int QW = sapc_pkg::QW;
	localparam int FB = sapc_pkg::FB;
	localparam int NST = sapc_pkg::NST;
	localparam int QD = 2;

	logic [15:0] min_span_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_span_q <= sapc_pkg::MIN_SPAN_RST;
		else if (cfg_we) min_span_q <= cfg_wdata;
	end

	// pipeline advances while the output queue has a free entry
	logic adv;
	logic [sapc_pkg::SW-1:0] cnt_q;
	logic [NST-1:0] v;
	assign adv = (cnt_q < sapc_pkg::SW'(QD));
	assign s_tready = adv;

	// stage 1: differences
	logic [2:0][CW-1:0] s_s1;
	logic [2:0][DW-1:0] d_s1;
	logic [DW-1:0] num_s1;
	logic [1:0] ax_s1;
	always_ff @(posedge clk) if (adv) begin
		for (int i = 0; i < 3; i++) begin
			s_s1[i] <= s_tdata[i*CW +: CW];
			d_s1[i] <= DW'($signed(s_tdata[(i+3)*CW +: CW])) - DW'($signed(s_tdata[i*CW +: CW]));
		end
		ax_s1 <= s_tuser;
		unique case (s_tuser)
			sapc_pkg::AX_X: num_s1 <= DW'($signed(s_tdata[6*CW +: CW])) - DW'($signed(s_tdata[0 +: CW]));
			sapc_pkg::AX_Y: num_s1 <= DW'($signed(s_tdata[6*CW +: CW])) - DW'($signed(s_tdata[CW +: CW]));
			default: num_s1 <= DW'($signed(s_tdata[6*CW +: CW])) - DW'($signed(s_tdata[2*CW +: CW]));
		endcase
	end

	// stage 2: magnitudes and miss checks
	logic [DW-1:0] span1, aspan1, anum1;
	logic ok1;
	always_comb begin
		unique case (ax_s1)
			sapc_pkg::AX_X: span1 = d_s1[0];
			sapc_pkg::AX_Y: span1 = d_s1[1];
			default: span1 = d_s1[2];
		endcase
		aspan1 = span1[DW-1] ? -span1 : span1;
		anum1 = num_s1[DW-1] ? -num_s1 : num_s1;
		ok1 = (ax_s1 != sapc_pkg::AX_NONE) && (span1 != '0) && (aspan1 >= DW'(min_span_q))
			&& !(num_s1 != '0 && (num_s1[DW-1] != span1[DW-1])) && (anum1 <= aspan1);
	end

	sapc_pkg::div_t dv [0:QW];
	always_ff @(posedge clk) if (adv) begin
		dv[0].ok <= ok1;
		dv[0].s <= s_s1;
		dv[0].d <= d_s1;
		dv[0].den <= aspan1;
		dv[0].rem <= {1'b0, anum1};
		dv[0].q <= '0;
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [DW:0] rs, df;
		assign rs = (k == 0) ? dv[k].rem : {dv[k].rem[DW-1:0], 1'b0};
		assign df = rs - {1'b0, dv[k].den};
		always_ff @(posedge clk) if (adv) begin
			dv[k+1].ok <= dv[k].ok;
			dv[k+1].s <= dv[k].s;
			dv[k+1].d <= dv[k].d;
			dv[k+1].den <= dv[k].den;
			dv[k+1].rem <= df[DW] ? rs : df;
			dv[k+1].q <= {dv[k].q[QW-2:0], ~df[DW]};
		end
	end

	// multiply stages: magnitude split into low 32 and high bit
	logic ok_m1, ok_m2, ok_m3;
	logic [2:0][CW-1:0] s_m1, s_m2, s_m3;
	logic [2:0] neg_m1, neg_m2, neg_m3;
	logic [2:0][DW-1:0] ad_m1;
	logic [QW-1:0] q_m1;
	logic [2:0][31+QW:0] plo_m2;
	logic [2:0][QW-1:0] phi_m2;
	logic [2:0][CW-1:0] r_m3;
	logic [2:0][CW-1:0] pt_m4;
	logic hit_m4;
	always_ff @(posedge clk) if (adv) begin
		ok_m1 <= dv[QW].ok;
		s_m1 <= dv[QW].s;
		q_m1 <= dv[QW].q;
		for (int i = 0; i < 3; i++) begin
			neg_m1[i] <= dv[QW].d[i][DW-1];
			ad_m1[i] <= dv[QW].d[i][DW-1] ? -dv[QW].d[i] : dv[QW].d[i];
		end
		ok_m2 <= ok_m1; s_m2 <= s_m1; neg_m2 <= neg_m1;
		for (int i = 0; i < 3; i++) begin
			plo_m2[i] <= (32+QW)'(ad_m1[i][31:0]) * (32+QW)'(q_m1);
			phi_m2[i] <= ad_m1[i][32] ? q_m1 : '0;
		end
		ok_m3 <= ok_m2; s_m3 <= s_m2; neg_m3 <= neg_m2;
		for (int i = 0; i < 3; i++)
			r_m3[i] <= CW'(((DW+QW)'(plo_m2[i]) + {phi_m2[i], 32'd0}
				+ (DW+QW)'(1 << (FB - 1))) >> FB);
		hit_m4 <= ok_m3;
		for (int i = 0; i < 3; i++)
			pt_m4[i] <= !ok_m3 ? '0 : neg_m3[i] ? s_m3[i] - r_m3[i]
				: s_m3[i] + r_m3[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (adv) v <= {v[NST-2:0], s_tvalid};
	end

	// output queue
	localparam int AW = $clog2(QD);
	logic [3*CW:0] mem_q [0:QD-1];
	logic [AW-1:0] wp_q, rp_q;
	logic push, pop;
	assign push = adv && v[NST-1];
	assign pop = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != '0;
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= {hit_m4, pt_m4[2], pt_m4[1], pt_m4[0]};
	assign m_tuser = mem_q[rp_q][3*CW];
	assign m_tdata = {8'd0, mem_q[rp_q][3*CW-1:0]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(QD-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(QD-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + sapc_pkg::SW'(push) - sapc_pkg::SW'(pop);
		end
	end

	`ASSERT_CLK(a_no_over, clk, arst_n, cnt_q <= sapc_pkg::SW'(QD), "queue overflow")
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, !adv, $stable(v), "pipeline moved in stall")
	`ASSERT_CLK(a_ready, clk, arst_n, s_tready == adv, "ready mismatch")
endmodule

[sim/sapc_checker.sv]
`timescale 1ns / 100ps
module sapc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [223:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	input  logic         m_tuser,
	output int           fail_count,
	output int           pending
);
	typedef struct {
		logic                   hit;
		logic [sapc_pkg::CW-1:0] px;
		logic [sapc_pkg::CW-1:0] py;
		logic [sapc_pkg::CW-1:0] pz;
	} clip_t;

	clip_t clip_q[$];
	logic [15:0] span_floor;

	// start + delta * frac / 2^FB, magnitude rounded half up
	function automatic logic [sapc_pkg::CW-1:0] lerp_axis(logic signed [63:0] st,
			logic signed [63:0] dl, logic [63:0] frac);
		logic [127:0] prod;
		logic [63:0] mag_d;
		logic [63:0] r;
		mag_d = dl < 0 ? -dl : dl;
		prod = mag_d * frac + (128'd1 << (sapc_pkg::FB - 1));
		r = prod >> sapc_pkg::FB;
		if (dl < 0)
			return st - r;
		return st + r;
	endfunction

	function automatic clip_t clip_segment(logic [1:0] ax, logic [223:0] d);
		clip_t res;
		logic signed [63:0] s[3];
		logic signed [63:0] dl[3];
		logic signed [63:0] pl, span, num;
		logic [63:0] aspan, anum, rem, frac;
		res = '{1'b0, '0, '0, '0};
		if (ax != sapc_pkg::AX_X && ax != sapc_pkg::AX_Y && ax != sapc_pkg::AX_Z)
			return res;
		for (int i = 0; i < 3; i++) begin
			s[i] = $signed(d[i*sapc_pkg::CW +: sapc_pkg::CW]);
			dl[i] = 64'($signed(d[(i+3)*sapc_pkg::CW +: sapc_pkg::CW])) - s[i];
		end
		pl = $signed(d[6*sapc_pkg::CW +: sapc_pkg::CW]);
		span = dl[ax];
		num = pl - s[ax];
		aspan = span < 0 ? -span : span;
		anum = num < 0 ? -num : num;
		if (span == 0 || aspan < span_floor)
			return res;
		if (num != 0 && ((num < 0) != (span < 0)))
			return res;
		if (anum > aspan)
			return res;
		rem = anum;
		frac = 0;
		if (rem >= aspan) begin
			frac = 1;
			rem -= aspan;
		end
		for (int i = 0; i < sapc_pkg::FB; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= aspan) begin
				rem -= aspan;
				frac[0] = 1'b1;
			end
		end
		res.hit = 1'b1;
		res.px = lerp_axis(s[0], dl[0], frac);
		res.py = lerp_axis(s[1], dl[1], frac);
		res.pz = lerp_axis(s[2], dl[2], frac);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		clip_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			span_floor <= sapc_pkg::MIN_SPAN_RST;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				span_floor <= cfg_wdata;
			if (s_tvalid && s_tready)
				clip_q.push_back(clip_segment(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (clip_q.size() == 0) begin
					$error("unexpected transaction: hit %0b data %h", m_tuser, m_tdata);
					errs = errs + 1;
				end else begin
					want = clip_q.pop_front();
					if (m_tuser !== want.hit) begin
						$error("hit: expected %0b actual %0b", want.hit, m_tuser);
						errs = errs + 1;
					end
					if (m_tdata[31:0] !== want.px) begin
						$error("point_x: expected %h actual %h", want.px, m_tdata[31:0]);
						errs = errs + 1;
					end
					if (m_tdata[63:32] !== want.py) begin
						$error("point_y: expected %h actual %h", want.py, m_tdata[63:32]);
						errs = errs + 1;
					end
					if (m_tdata[95:64] !== want.pz) begin
						$error("point_z: expected %h actual %h", want.pz, m_tdata[95:64]);
						errs = errs + 1;
					end
					if (m_tdata[103:96] !== 8'd0) begin
						$error("pad: expected 00 actual %h", m_tdata[103:96]);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending <= clip_q.size();
		end
	end
endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;
	logic         m_tuser;
	int           fail_count;
	int           pending;
	int           idle_cycles = 0;
	bit           hold_long = 1'b0;
	bit           hold_done = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_axis_plane_clip dut (.*);

	sapc_checker chk (.*);

	// sink: random stalls, one long hold-off on request
	always @(posedge clk) begin
		int w;
		if (arst_n) begin
			if (hold_long && !hold_done) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if ($urandom_range(0, 1)) w = 0;
			m_tready <= 1'b0;
			repeat (w) @(posedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 8000)) - 4000);
			default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	// one transaction; gap drawn unless burst
	task automatic send_seg(logic [1:0] ax, logic [223:0] d, bit burst);
		int gap;
		gap = burst ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19));
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= ax;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (sapc_pkg::NST + 10) @(posedge clk);
	endtask

	task automatic set_floor(logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [223:0] pack_seg(logic [31:0] sx, sy, sz, ex, ey, ez, pl);
		return {pl, ez, ey, ex, sz, sy, sx};
	endfunction

	// hit-biased segment: plane chosen between start and end on the axis
	function automatic logic [223:0] rand_seg(output logic [1:0] ax);
		logic [31:0] c[6];
		logic signed [63:0] a, b, p;
		int mode;
		mode = $urandom_range(0, 2);
		for (int i = 0; i < 6; i++) c[i] = rand_coord(mode);
		ax = $urandom_range(0, 9) == 0 ? sapc_pkg::AX_NONE : 2'($urandom_range(0, 2));
		a = $signed(c[ax == sapc_pkg::AX_NONE ? 0 : ax]);
		b = $signed(c[ax == sapc_pkg::AX_NONE ? 3 : ax + 3]);
		if ($urandom_range(0, 4) != 0)
			p = a + ((b - a) * $signed({1'b0, $urandom_range(0, 1024)})) / 1024;
		else
			p = $signed(rand_coord(mode));
		return pack_seg(c[0], c[1], c[2], c[3], c[4], c[5], p[31:0]);
	endfunction

	initial begin
		logic [1:0] ax;
		logic [223:0] d;
		logic [15:0] floors[4];
		floors = '{16'd0, 16'hFFFF, 16'd100, 16'd1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send_seg(sapc_pkg::AX_X,
			pack_seg(0, 0, 0, 32'h1000, 32'h2000, 32'h3000, 32'h800), 0);
		send_seg(sapc_pkg::AX_Y, pack_seg(5, 6, 7, 100, 200, 300, 6), 0);
		send_seg(sapc_pkg::AX_Z, pack_seg(5, 6, 7, 100, 200, 300, 300), 0);
		send_seg(sapc_pkg::AX_Z, pack_seg(5, 6, 7, 100, 200, 300, 301), 0);
		send_seg(sapc_pkg::AX_X, pack_seg(5, 6, 7, 4, 200, 300, 5), 0);
		send_seg(sapc_pkg::AX_X, pack_seg(5, 6, 7, 6, 200, 300, 5), 0);
		send_seg(sapc_pkg::AX_X, pack_seg(5, 6, 7, 5, 200, 300, 5), 0);
		send_seg(sapc_pkg::AX_NONE, pack_seg(0, 0, 0, 100, 100, 100, 50), 0);
		send_seg(sapc_pkg::AX_X, pack_seg(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0), 0);
		send_seg(sapc_pkg::AX_Y, pack_seg(32'h7FFFFFFF, 32'h7FFFFFFF, 0,
			32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'h80000000), 0);
		send_seg(sapc_pkg::AX_Z, pack_seg(1, 2, 32'hFFFFFFFF, 3, 4,
			32'h80000000, 32'hFFFFFFFF), 0);
		send_seg(sapc_pkg::AX_X, pack_seg(0, 0, 0, 32'hFFFFFFFD, 7, 9, 32'hFFFFFFFF), 0);
		send_seg(sapc_pkg::AX_X, pack_seg(0, 0, 0, 3, 7, 9, 32'hFFFFFFFF), 0);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			if (ph > 0)
				set_floor(floors[ph - 1]);
			for (int n = 0; n < 200; n++) begin
				d = rand_seg(ax);
				send_seg(ax, d, ph == 2 && n > 20 && n < 120);
				if (ph == 2 && n == 20)
					hold_long = 1'b1;
			end
			drain();
		end

		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
